FILE: rtl/cid_pkg.sv
// Shared types and widths for the cubic interpolator with derivatives.
// No dependencies; cid_lane, cid_merge and the top file refer to it by scoped names.
package cid_pkg;

  localparam int unsigned DATA_W  = 32;  // Q16.16 field width
  localparam int unsigned DIFF_W  = 33;  // difference of two fields
  localparam int unsigned QQ_W    = 36;  // 2 * (3q - three abscissae)
  localparam int unsigned P2_W    = 66;  // product of two differences
  localparam int unsigned QDF_W   = 69;  // curvature factor times ordinate difference
  localparam int unsigned SS_W    = 68;  // sum of three pairwise products
  localparam int unsigned P3_W    = 99;  // product of three differences
  localparam int unsigned NS_W    = 101; // slope numerator before scaling
  localparam int unsigned NUM_W   = 132; // numerator and quotient width
  localparam int unsigned SUM_W   = 134; // f0 plus three terms
  localparam int unsigned LANE_LAT = NUM_W + 8;
  localparam int unsigned PIPE_LAT = LANE_LAT + 1;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] point_x0;
    logic signed [DATA_W-1:0] point_x1;
    logic signed [DATA_W-1:0] point_x2;
    logic signed [DATA_W-1:0] point_x3;
    logic signed [DATA_W-1:0] value_f0;
    logic signed [DATA_W-1:0] value_f1;
    logic signed [DATA_W-1:0] value_f2;
    logic signed [DATA_W-1:0] value_f3;
    logic signed [DATA_W-1:0] query_point;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] interp_value;
    logic signed [DATA_W-1:0] first_derivative;
    logic signed [DATA_W-1:0] second_derivative;
    logic                     degenerate;
  } out_t;

endpackage

FILE: rtl/cid_div.sv
// Pipelined signed divider, rounded to nearest with halves away from zero.
// One quotient bit per stage; depends on nothing but its parameters.
module cid_div #(
  parameter int unsigned NW = 132,
  parameter int unsigned DW = 99
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic signed [NW-1:0] quo
);

  logic [DW-1:0] rem [0:NW];
  logic [NW-1:0] qn  [0:NW];
  logic [DW-1:0] dm  [0:NW];
  logic          neg [0:NW];

  logic [DW-1:0] rem_next [1:NW];
  logic [NW-1:0] qn_next  [1:NW];

  logic [NW-1:0] nm_abs;
  logic [DW-1:0] dm_abs;

  always_comb begin
    nm_abs = num[NW-1] ? NW'(-num) : NW'(num);
    dm_abs = den[DW-1] ? DW'(-den) : DW'(den);
  end

  always_comb begin
    logic [DW:0] trial;
    logic [DW:0] diff;
    for (int s = 1; s <= NW; s++) begin
      trial = {rem[s-1], qn[s-1][NW-1]};
      diff  = trial - {1'b0, dm[s-1]};
      if (trial >= {1'b0, dm[s-1]}) begin
        rem_next[s] = diff[DW-1:0];
        qn_next[s]  = {qn[s-1][NW-2:0], 1'b1};
      end else begin
        rem_next[s] = trial[DW-1:0];
        qn_next[s]  = {qn[s-1][NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // add half the divisor so truncation rounds to nearest
      rem[0] <= '0;
      qn[0]  <= nm_abs + NW'(dm_abs >> 1);
      dm[0]  <= dm_abs;
      neg[0] <= num[NW-1] ^ den[DW-1];
      for (int s = 1; s <= NW; s++) begin
        rem[s] <= rem_next[s];
        qn[s]  <= qn_next[s];
        dm[s]  <= dm[s-1];
        neg[s] <= neg[s-1];
      end
      quo <= neg[NW] ? $signed(-qn[NW]) : $signed(qn[NW]);
    end
  end

endmodule

FILE: rtl/cid_lane.sv
// One lane: value, slope and curvature terms for one ordinate k,
// plus the chunked multiplier it uses. Depends on cid_pkg and cid_div.
module cid_lane (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [cid_pkg::DATA_W-1:0]   xk,
  input  logic signed [cid_pkg::DATA_W-1:0]   xo0,
  input  logic signed [cid_pkg::DATA_W-1:0]   xo1,
  input  logic signed [cid_pkg::DATA_W-1:0]   xo2,
  input  logic signed [cid_pkg::DATA_W-1:0]   fk,
  input  logic signed [cid_pkg::DATA_W-1:0]   f0,
  input  logic signed [cid_pkg::DATA_W-1:0]   q,
  output logic signed [cid_pkg::NUM_W-1:0]    term_v,
  output logic signed [cid_pkg::NUM_W-1:0]    term_s,
  output logic signed [cid_pkg::NUM_W-1:0]    term_c
);

  // stage 1
  logic signed [cid_pkg::DIFF_W-1:0] e0, e1, e2, dxa, dxb, dxc, df1;
  logic signed [cid_pkg::QQ_W-1:0]   qq;
  // stage 2
  logic signed [cid_pkg::P2_W-1:0]   p01, p02, p12, dab;
  logic signed [cid_pkg::QDF_W-1:0]  qdf2;
  logic signed [cid_pkg::DIFF_W-1:0] e2_2, dxc2, df2;
  // stage 3
  logic signed [cid_pkg::SS_W-1:0]   ss;
  logic signed [cid_pkg::QDF_W-1:0]  qdf3;
  logic signed [cid_pkg::DIFF_W-1:0] df3;
  // stage 4
  logic signed [cid_pkg::P3_W-1:0]   nn, den4;
  logic signed [cid_pkg::SS_W-1:0]   ss4;
  logic signed [cid_pkg::QDF_W-1:0]  qdf4;
  logic signed [cid_pkg::DIFF_W-1:0] df4;
  // stage 5
  logic signed [cid_pkg::P3_W-1:0]   den5;
  logic signed [cid_pkg::QDF_W-1:0]  qdf5;
  // stage 6
  logic signed [cid_pkg::NUM_W-1:0]  nv;
  logic signed [cid_pkg::NS_W-1:0]   ns;
  logic signed [cid_pkg::P3_W-1:0]   den6;
  logic signed [cid_pkg::QDF_W-1:0]  qdf6;

  logic signed [cid_pkg::NUM_W-1:0]  num_s, num_c;

  always_ff @(posedge clk) begin
    if (en) begin
      e0  <= cid_pkg::DIFF_W'(q) - cid_pkg::DIFF_W'(xo0);
      e1  <= cid_pkg::DIFF_W'(q) - cid_pkg::DIFF_W'(xo1);
      e2  <= cid_pkg::DIFF_W'(q) - cid_pkg::DIFF_W'(xo2);
      dxa <= cid_pkg::DIFF_W'(xk) - cid_pkg::DIFF_W'(xo0);
      dxb <= cid_pkg::DIFF_W'(xk) - cid_pkg::DIFF_W'(xo1);
      dxc <= cid_pkg::DIFF_W'(xk) - cid_pkg::DIFF_W'(xo2);
      df1 <= cid_pkg::DIFF_W'(fk) - cid_pkg::DIFF_W'(f0);
      qq  <= (cid_pkg::QQ_W'(q) + cid_pkg::QQ_W'(q) + cid_pkg::QQ_W'(q)
              - cid_pkg::QQ_W'(xo0) - cid_pkg::QQ_W'(xo1) - cid_pkg::QQ_W'(xo2)) <<< 1;

      p01  <= e0 * e1;
      p02  <= e0 * e2;
      p12  <= e1 * e2;
      dab  <= dxa * dxb;
      qdf2 <= qq * df1;
      e2_2 <= e2;
      dxc2 <= dxc;
      df2  <= df1;

      ss   <= cid_pkg::SS_W'(p01) + cid_pkg::SS_W'(p02) + cid_pkg::SS_W'(p12);
      qdf3 <= qdf2;
      df3  <= df2;

      ss4  <= ss;
      qdf4 <= qdf3;
      df4  <= df3;

      den5 <= den4;
      qdf5 <= qdf4;

      den6 <= den5;
      qdf6 <= qdf5;
    end
  end

  cid_mul #(.AW(cid_pkg::P2_W), .BW(cid_pkg::DIFF_W)) u_mul_n (
    .clk(clk), .en(en), .a(p01), .b(e2_2), .p(nn)
  );
  cid_mul #(.AW(cid_pkg::P2_W), .BW(cid_pkg::DIFF_W)) u_mul_d (
    .clk(clk), .en(en), .a(dab), .b(dxc2), .p(den4)
  );
  cid_mul #(.AW(cid_pkg::P3_W), .BW(cid_pkg::DIFF_W)) u_mul_v (
    .clk(clk), .en(en), .a(nn), .b(df4), .p(nv)
  );
  cid_mul #(.AW(cid_pkg::SS_W), .BW(cid_pkg::DIFF_W)) u_mul_s (
    .clk(clk), .en(en), .a(ss4), .b(df4), .p(ns)
  );

  assign num_s = cid_pkg::NUM_W'(ns) <<< 16;
  assign num_c = cid_pkg::NUM_W'(qdf6) <<< 32;

  cid_div #(.NW(cid_pkg::NUM_W), .DW(cid_pkg::P3_W)) u_div_v (
    .clk(clk), .en(en), .num(nv), .den(den6), .quo(term_v)
  );
  cid_div #(.NW(cid_pkg::NUM_W), .DW(cid_pkg::P3_W)) u_div_s (
    .clk(clk), .en(en), .num(num_s), .den(den6), .quo(term_s)
  );
  cid_div #(.NW(cid_pkg::NUM_W), .DW(cid_pkg::P3_W)) u_div_c (
    .clk(clk), .en(en), .num(num_c), .den(den6), .quo(term_c)
  );

endmodule

// Signed wide-by-narrow product: the wide operand is cut into
// 33-bit chunks, each chunk product is registered, then the shifted products are summed into registered p.
module cid_mul #(
  parameter int unsigned AW = 66,
  parameter int unsigned BW = 33
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int unsigned CW = 33;
  localparam int unsigned NC = (AW + CW - 1) / CW;
  localparam int unsigned PW = AW + BW;

  logic signed [NC*CW-1:0] a_ext;
  logic signed [CW:0]      chunk [0:NC-1];
  logic signed [CW+BW:0]   pp    [0:NC-1];
  logic signed [PW-1:0]    acc;

  always_comb begin
    a_ext = (NC*CW)'(a);
    // low chunks are unsigned, the top chunk carries the sign
    for (int i = 0; i < NC; i++) begin
      if (i == NC - 1) chunk[i] = {a_ext[NC*CW-1], a_ext[i*CW +: CW]};
      else             chunk[i] = {1'b0, a_ext[i*CW +: CW]};
    end
    acc = '0;
    for (int i = 0; i < NC; i++) acc = acc + (PW'(pp[i]) <<< (i*CW));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NC; i++) pp[i] <= chunk[i] * b;
      p <= acc;
    end
  end

endmodule

FILE: rtl/cid_merge.sv
// Merge stage: sums the lane terms (plus f0 for the value), saturates to Q16.16, applies the degenerate flag.
// Depends on cid_pkg.
module cid_merge (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [cid_pkg::DATA_W-1:0] f0,
  input  logic                              degen,
  input  logic signed [cid_pkg::NUM_W-1:0]  v1, v2, v3,
  input  logic signed [cid_pkg::NUM_W-1:0]  s1, s2, s3,
  input  logic signed [cid_pkg::NUM_W-1:0]  c1, c2, c3,
  output cid_pkg::out_t                     result
);

  logic signed [cid_pkg::SUM_W-1:0] sum_v, sum_s, sum_c;
  logic                             degen_r;

  function automatic logic signed [cid_pkg::DATA_W-1:0] sat(
    input logic signed [cid_pkg::SUM_W-1:0] a
  );
    logic signed [cid_pkg::DATA_W-1:0] r;
    if (a > cid_pkg::SUM_W'(cid_pkg::SAT_MAX))      r = cid_pkg::SAT_MAX;
    else if (a < cid_pkg::SUM_W'(cid_pkg::SAT_MIN)) r = cid_pkg::SAT_MIN;
    else                                            r = a[cid_pkg::DATA_W-1:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      sum_v   <= cid_pkg::SUM_W'(f0) + cid_pkg::SUM_W'(v1) + cid_pkg::SUM_W'(v2)
                 + cid_pkg::SUM_W'(v3);
      sum_s   <= cid_pkg::SUM_W'(s1) + cid_pkg::SUM_W'(s2) + cid_pkg::SUM_W'(s3);
      sum_c   <= cid_pkg::SUM_W'(c1) + cid_pkg::SUM_W'(c2) + cid_pkg::SUM_W'(c3);
      degen_r <= degen;
    end
  end

  always_comb begin
    result.degenerate = degen_r;
    if (degen_r) begin
      result.interp_value      = '0;
      result.first_derivative  = '0;
      result.second_derivative = '0;
    end else begin
      result.interp_value      = sat(sum_v);
      result.first_derivative  = sat(sum_s);
      result.second_derivative = sat(sum_c);
    end
  end

endmodule

FILE: rtl/cubic_interp_with_derivatives.sv
// Cubic interpolation with first and second derivatives, Q16.16, three parallel lanes.
// Throughput: one item per cycle while not stalled; the pipeline depth is set by the pipelined dividers.
// Stalls only when both the output register and the skid register are full.
// Reset (synchronous, rst high) clears all valid bits; payload registers are not reset.
// Depends on cid_pkg, cid_lane (with cid_mul), cid_div and cid_merge.
module cubic_interp_with_derivatives (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cid_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cid_pkg::out_t out_data
);

  logic en;
  logic vld [0:cid_pkg::PIPE_LAT-1];
  logic signed [cid_pkg::DATA_W-1:0] f0_pipe  [0:cid_pkg::LANE_LAT-1];
  logic                              deg_pipe [0:cid_pkg::LANE_LAT-1];
  logic degen_in;

  logic signed [cid_pkg::NUM_W-1:0] tv [1:3];
  logic signed [cid_pkg::NUM_W-1:0] ts [1:3];
  logic signed [cid_pkg::NUM_W-1:0] tc [1:3];

  cid_pkg::out_t merged;
  logic          skid_valid;
  cid_pkg::out_t skid_data;
  logic          pv;

  assign en       = !skid_valid;
  assign in_ready = en;
  assign pv       = vld[cid_pkg::PIPE_LAT-1];

  assign degen_in = (in_data.point_x0 == in_data.point_x1) ||
                    (in_data.point_x0 == in_data.point_x2) ||
                    (in_data.point_x0 == in_data.point_x3) ||
                    (in_data.point_x1 == in_data.point_x2) ||
                    (in_data.point_x1 == in_data.point_x3) ||
                    (in_data.point_x2 == in_data.point_x3);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cid_pkg::PIPE_LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < cid_pkg::PIPE_LAT; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0_pipe[0]  <= in_data.value_f0;
      deg_pipe[0] <= degen_in;
      for (int i = 1; i < cid_pkg::LANE_LAT; i++) begin
        f0_pipe[i]  <= f0_pipe[i-1];
        deg_pipe[i] <= deg_pipe[i-1];
      end
    end
  end

  cid_lane u_lane1 (
    .clk(clk), .en(en), .xk(in_data.point_x1),
    .xo0(in_data.point_x0), .xo1(in_data.point_x2), .xo2(in_data.point_x3),
    .fk(in_data.value_f1), .f0(in_data.value_f0), .q(in_data.query_point),
    .term_v(tv[1]), .term_s(ts[1]), .term_c(tc[1])
  );
  cid_lane u_lane2 (
    .clk(clk), .en(en), .xk(in_data.point_x2),
    .xo0(in_data.point_x0), .xo1(in_data.point_x1), .xo2(in_data.point_x3),
    .fk(in_data.value_f2), .f0(in_data.value_f0), .q(in_data.query_point),
    .term_v(tv[2]), .term_s(ts[2]), .term_c(tc[2])
  );
  cid_lane u_lane3 (
    .clk(clk), .en(en), .xk(in_data.point_x3),
    .xo0(in_data.point_x0), .xo1(in_data.point_x1), .xo2(in_data.point_x2),
    .fk(in_data.value_f3), .f0(in_data.value_f0), .q(in_data.query_point),
    .term_v(tv[3]), .term_s(ts[3]), .term_c(tc[3])
  );

  cid_merge u_merge (
    .clk(clk), .en(en),
    .f0(f0_pipe[cid_pkg::LANE_LAT-1]), .degen(deg_pipe[cid_pkg::LANE_LAT-1]),
    .v1(tv[1]), .v2(tv[2]), .v3(tv[3]),
    .s1(ts[1]), .s2(ts[2]), .s3(ts[3]),
    .c1(tc[1]), .c2(tc[2]), .c3(tc[3]),
    .result(merged)
  );

  // output register with skid: a result arriving while the output stalls waits in skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (out_valid && !out_ready) begin
      if (pv) skid_valid <= 1'b1;
    end else begin
      out_valid <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) out_data <= skid_data;
    end else if (out_valid && !out_ready) begin
      if (pv) skid_data <= merged;
    end else begin
      out_data <= merged;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid holds data while output is empty");

  a_skid_blocks_input: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !in_ready) else $error("input accepted while skid is full");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.degenerate) |-> (out_data.interp_value == 0 &&
      out_data.first_derivative == 0 && out_data.second_derivative == 0))
    else $error("degenerate result carries nonzero values");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_valid && !skid_valid)) else $error("valid set after reset");
`endif

endmodule
